// ===== sv/ipp_pkg.sv =====
// Shared types, character codes and result kinds for the address text parser.
`timescale 1ns / 1ps
`default_nettype none

package ipp_pkg;

    // Character codes that steer the parsers.
    localparam logic [7:0] CHAR_END   = 8'h00;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;

    // Address geometry.
    localparam int GROUPS    = 8;
    localparam int OCTETS    = 4;
    localparam int MAX_HEX   = 4;
    localparam logic [9:0] OCTET_MAX = 10'd255;

    // Result kinds.
    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_IPV4    = 2'd1;
    localparam logic [1:0] KIND_IPV6    = 2'd2;

    // Verdict of the IPv6 parser for the string that ends now.
    typedef struct packed {
        logic        ok;
        logic        colon_seen;
        logic [63:0] hi;
        logic [63:0] lo;
    } six_res_t;

    // Verdict of the IPv4 parser for the string that ends now.
    typedef struct packed {
        logic        ok;
        logic [63:0] lo;
    } four_res_t;

endpackage

`default_nettype wire

// ===== sv/ip_address_text_parser_top.sv =====
// Top level: input register, parallel IPv4 and IPv6 lanes, result register.
// Lanes update in a single step; the result register takes a result as its end byte steps.
// Throughput: one character per cycle, except that an end byte waits on a busy result slot.
// A result is held in the output register while the next characters keep flowing.
// Reset: rst_n clears all parser state and both valid flags asynchronously.
`timescale 1ns / 1ps
`default_nettype none

module ip_address_text_parser_top
    import ipp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // char_code [7:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata    // kind [1:0], addr_upper [65:2], addr_lower [129:66]
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       out_valid_reg;
    logic [1:0] kind_reg, kind_next;
    logic [63:0] upper_reg, upper_next;
    logic [63:0] lower_reg, lower_next;

    logic       is_end;
    logic       out_free;
    logic       step;
    six_res_t   six_res;
    four_res_t  four_res;

    // The held character moves on unless it ends a string and the result slot is busy.
    assign is_end   = (in_char_reg == CHAR_END);
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!is_end || out_free);
    assign s_tready = !in_valid_reg || step;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
        end
    end

    ipp_six u_six (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_code (in_char_reg),
        .res       (six_res)
    );

    ipp_four u_four (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_code (in_char_reg),
        .res       (four_res)
    );

    // Pick the verdict: any colon selects IPv6.
    always_comb
    begin
        kind_next  = KIND_INVALID;
        upper_next = 64'd0;
        lower_next = 64'd0;
        if (six_res.colon_seen)
        begin
            if (six_res.ok)
            begin
                kind_next  = KIND_IPV6;
                upper_next = six_res.hi;
                lower_next = six_res.lo;
            end
        end
        else if (four_res.ok)
        begin
            kind_next  = KIND_IPV4;
            lower_next = four_res.lo;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && is_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && is_end)
        begin
            kind_reg  <= kind_next;
            upper_reg <= upper_next;
            lower_reg <= lower_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, lower_reg, upper_reg, kind_reg};

endmodule

`default_nettype wire

// ===== sv/ipp_six.sv =====
// IPv6 colon-hex parser lane with gap expansion at the end of the string.
`timescale 1ns / 1ps
`default_nettype none

module ipp_six
    import ipp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_code,
    output six_res_t        res
);

    logic [15:0] store_reg [GROUPS];
    logic [15:0] store_next [GROUPS];
    logic [3:0]  count_reg, count_next;
    logic [3:0]  gap_pos_reg, gap_pos_next;
    logic        gap_found_reg, gap_found_next;
    logic [15:0] accum_reg, accum_next;
    logic [2:0]  digits_reg, digits_next;
    logic        prev_reg, prev_next;
    logic        colon_reg, colon_next;
    logic        err_reg, err_next;
    logic        full_reg, full_next;

    logic        is_hex;
    logic [3:0]  hex_val;

    // Hex digit decode.
    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (char_code inside {[CHAR_0:CHAR_9]})
        begin
            hex_val = 4'(char_code - CHAR_0);
        end
        else if (char_code inside {[CHAR_LA:CHAR_LF]})
        begin
            hex_val = 4'(char_code - CHAR_LA + 8'd10);
        end
        else if (char_code inside {[CHAR_UA:CHAR_UF]})
        begin
            hex_val = 4'(char_code - CHAR_UA + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // Per-character state update; the end byte clears everything.
    always_comb
    begin
        store_next     = store_reg;
        count_next     = count_reg;
        gap_pos_next   = gap_pos_reg;
        gap_found_next = gap_found_reg;
        accum_next     = accum_reg;
        digits_next    = digits_reg;
        prev_next      = prev_reg;
        colon_next     = colon_reg;
        err_next       = err_reg;
        full_next      = full_reg;
        if (step)
        begin
            if (char_code == CHAR_END)
            begin
                for (int i = 0; i < GROUPS; i++)
                begin
                    store_next[i] = 16'd0;
                end
                count_next     = 4'd0;
                gap_pos_next   = 4'd0;
                gap_found_next = 1'b0;
                accum_next     = 16'd0;
                digits_next    = 3'd0;
                prev_next      = 1'b0;
                colon_next     = 1'b0;
                err_next       = 1'b0;
                full_next      = 1'b0;
            end
            else
            begin
                if (char_code == CHAR_COLON)
                begin
                    colon_next = 1'b1;
                end
                if (!full_reg && !err_reg)
                begin
                    if (char_code == CHAR_COLON)
                    begin
                        if (prev_reg && !gap_found_reg)
                        begin
                            gap_found_next = 1'b1;
                            gap_pos_next   = count_reg;
                            prev_next      = 1'b0;
                        end
                        else
                        begin
                            // Flush a pending group before the colon counts.
                            if (digits_reg != 3'd0 && !count_reg[3])
                            begin
                                store_next[count_reg[2:0]] = accum_reg;
                                count_next  = count_reg + 4'd1;
                                accum_next  = 16'd0;
                                digits_next = 3'd0;
                                full_next   = (count_reg == 4'(GROUPS - 1));
                            end
                            prev_next = 1'b1;
                        end
                    end
                    else if (is_hex)
                    begin
                        prev_next = 1'b0;
                        if (digits_reg < 3'(MAX_HEX))
                        begin
                            accum_next  = {accum_reg[11:0], hex_val};
                            digits_next = digits_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUPS; i++)
            begin
                store_reg[i] <= 16'd0;
            end
            count_reg     <= 4'd0;
            gap_pos_reg   <= 4'd0;
            gap_found_reg <= 1'b0;
            accum_reg     <= 16'd0;
            digits_reg    <= 3'd0;
            prev_reg      <= 1'b0;
            colon_reg     <= 1'b0;
            err_reg       <= 1'b0;
            full_reg      <= 1'b0;
        end
        else
        begin
            store_reg     <= store_next;
            count_reg     <= count_next;
            gap_pos_reg   <= gap_pos_next;
            gap_found_reg <= gap_found_next;
            accum_reg     <= accum_next;
            digits_reg    <= digits_next;
            prev_reg      <= prev_next;
            colon_reg     <= colon_next;
            err_reg       <= err_next;
            full_reg      <= full_next;
        end
    end

    // End-of-string view: final flush, then gap expansion.
    logic        fin_flush;
    logic [3:0]  fin_count;
    logic        expand;
    logic [15:0] merged [GROUPS];
    logic [15:0] grp [GROUPS];
    logic [4:0]  shift_pos;
    logic [2:0]  src_idx;

    always_comb
    begin
        fin_flush = (digits_reg != 3'd0) && !count_reg[3];
        fin_count = count_reg + {3'd0, fin_flush};
        expand    = gap_found_reg && !fin_count[3];
        shift_pos = 5'd0;
        src_idx   = 3'd0;
        for (int i = 0; i < GROUPS; i++)
        begin
            merged[i] = (fin_flush && count_reg[2:0] == 3'(i)) ? accum_reg : store_reg[i];
        end
        for (int i = 0; i < GROUPS; i++)
        begin
            grp[i] = merged[i];
            if (expand && 4'(i) >= gap_pos_reg)
            begin
                // Tail groups land at the top; the groups in between read zero.
                shift_pos = 5'(i) + {1'b0, fin_count} - {1'b0, gap_pos_reg};
                src_idx   = 3'(i) + fin_count[2:0];
                grp[i]    = (shift_pos >= 5'(GROUPS)) ? merged[src_idx] : 16'd0;
            end
        end
        res.ok         = !err_reg;
        res.colon_seen = colon_reg;
        res.hi         = {grp[0], grp[1], grp[2], grp[3]};
        res.lo         = {grp[4], grp[5], grp[6], grp[7]};
    end

endmodule

`default_nettype wire

// ===== sv/ipp_four.sv =====
// IPv4 dotted-decimal parser lane.
`timescale 1ns / 1ps
`default_nettype none

module ipp_four
    import ipp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_code,
    output four_res_t       res
);

    logic [7:0] store_reg [OCTETS];
    logic [7:0] store_next [OCTETS];
    logic [9:0] accum_reg, accum_next;
    logic [1:0] digits_reg, digits_next;
    logic [2:0] count_reg, count_next;
    logic       err_reg, err_next;

    logic       is_digit;
    logic       end_ok;

    assign is_digit = char_code inside {[CHAR_0:CHAR_9]};
    assign end_ok   = (digits_reg != 2'd0) && (accum_reg <= OCTET_MAX)
                      && (count_reg < 3'(OCTETS));

    // Per-character state update; the end byte clears everything.
    always_comb
    begin
        store_next  = store_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        if (step)
        begin
            if (char_code == CHAR_END)
            begin
                for (int i = 0; i < OCTETS; i++)
                begin
                    store_next[i] = 8'd0;
                end
                accum_next  = 10'd0;
                digits_next = 2'd0;
                count_next  = 3'd0;
                err_next    = 1'b0;
            end
            else if (!err_reg)
            begin
                if (char_code == CHAR_DOT)
                begin
                    if (end_ok)
                    begin
                        store_next[count_reg[1:0]] = accum_reg[7:0];
                        count_next  = count_reg + 3'd1;
                        accum_next  = 10'd0;
                        digits_next = 2'd0;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (is_digit)
                begin
                    if (digits_reg > 2'd2)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        // The accumulator stays below 100 here, so ten times it fits.
                        accum_next  = 10'({accum_reg, 3'b000} + {accum_reg, 1'b0}
                                      + 13'(char_code - CHAR_0));
                        digits_next = digits_reg + 2'd1;
                    end
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OCTETS; i++)
            begin
                store_reg[i] <= 8'd0;
            end
            accum_reg  <= 10'd0;
            digits_reg <= 2'd0;
            count_reg  <= 3'd0;
            err_reg    <= 1'b0;
        end
        else
        begin
            store_reg  <= store_next;
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
        end
    end

    // End-of-string verdict: the end byte closes the fourth octet.
    always_comb
    begin
        res.ok = !err_reg && end_ok && (count_reg == 3'(OCTETS - 1));
        res.lo = {32'd0, accum_reg[7:0], store_reg[2], store_reg[1], store_reg[0]};
    end

endmodule

`default_nettype wire
